FILE: rtl/stf_pkg.sv
// Package for the sorted key/value table: field widths, request and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package stf_pkg;

  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned VAL_IN_W   = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned POS_W      = 9;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_FIND   = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SH_PRIME,
    S_SH_STEP,
    S_WR_NEW,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load_req;
    logic    search_rd;
    logic    search_upd;
    logic    wr_replace;
    logic    shift_prime;
    logic    shift_step;
    logic    wr_new;
    logic    load_rsp;
    status_e rsp_status;
  } stf_cmd_t;

  typedef struct packed {
    logic search_busy;
    logic is_find;
    logic hit;
    logic full;
    logic need_shift;
    logic shift_last;
    logic out_free;
  } stf_stat_t;

endpackage

FILE: rtl/stf_req_if.sv
// Request channel of the sorted table: valid/ready plus one request item.
// Depends on stf_pkg for the field widths.
interface stf_req_if
  import stf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [KEY_IN_W-1:0] key;
  logic [VAL_IN_W-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

FILE: rtl/stf_rsp_if.sv
// Response channel of the sorted table: valid/ready plus one result item.
// Depends on stf_pkg for the field widths.
interface stf_rsp_if
  import stf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [VAL_IN_W-1:0] stored_value;
  logic [POS_W-1:0]    entry_count;

  modport source (output valid, status, position, stored_value, entry_count, input ready);
  modport sink   (input valid, status, position, stored_value, entry_count, output ready);
endinterface

FILE: rtl/stf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/stf_ctrl.sv
// Controller of the sorted table: sequences search, replace, shift and
// insert for one item at a time. Depends on stf_pkg.
module stf_ctrl
  import stf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  stf_stat_t stat_i,
  output stf_cmd_t  cmd_o
);
  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_d = stat_i.search_busy ? S_SRCH_CMP : S_DECIDE;
      end
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_DECIDE: begin
        if (stat_i.is_find) begin
          st_d    = stat_i.hit ? ST_FOUND : ST_MISSING;
          state_d = S_RESP;
        end else if (stat_i.hit) begin
          st_d    = ST_REPLACED;
          state_d = S_RESP;
        end else if (stat_i.full) begin
          st_d    = ST_FULL;
          state_d = S_RESP;
        end else begin
          st_d    = ST_INSERTED;
          state_d = stat_i.need_shift ? S_SH_PRIME : S_WR_NEW;
        end
      end
      S_SH_PRIME: state_d = S_SH_STEP;
      S_SH_STEP: begin
        if (stat_i.shift_last) begin
          state_d = S_WR_NEW;
        end
      end
      S_WR_NEW: state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.rsp_status = st_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_SRCH_RD:  cmd_o.search_rd = stat_i.search_busy;
      S_SRCH_CMP: cmd_o.search_upd = 1'b1;
      S_DECIDE: begin
        cmd_o.wr_replace = !stat_i.is_find && stat_i.hit;
      end
      S_SH_PRIME: cmd_o.shift_prime = 1'b1;
      S_SH_STEP:  cmd_o.shift_step = 1'b1;
      S_WR_NEW:   cmd_o.wr_new = 1'b1;
      S_RESP:     cmd_o.load_rsp = stat_i.out_free;
      default: ;
    endcase
  end
endmodule

FILE: rtl/stf_dp.sv
// Datapath of the sorted table: request registers, search bounds, entry
// count, the entry memory and the result register. Depends on stf_pkg, stf_ram.
module stf_dp
  import stf_pkg::*;
#(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_type_i,
  input  logic [KEY_IN_W-1:0] key_i,
  input  logic [VAL_IN_W-1:0] value_i,
  input  stf_cmd_t            cmd_i,
  output stf_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [VAL_IN_W-1:0] stored_value_o,
  output logic [POS_W-1:0]    entry_count_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_WIDTH + VALUE_WIDTH;

  logic                   req_type_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_in_q;
  logic [CW-1:0]          lo_q, hi_q, used_q, sh_q;
  logic                   eq_q;
  logic [VALUE_WIDTH-1:0] hitval_q;

  logic [63:0]            key_ext, val_ext, hitval_ext;
  logic [31:0]            lo_ext, used_ext;
  logic [CW-1:0]          mid, used_m1, sh_m1, sh_m2;
  logic [EW-1:0]          rdata, wdata;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [AW-1:0]          raddr, waddr;
  logic                   we;

  assign key_ext = {32'd0, key_i};
  assign val_ext = {32'd0, value_i};
  assign rd_key  = rdata[EW-1:VALUE_WIDTH];
  assign rd_val  = rdata[VALUE_WIDTH-1:0];
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign used_m1 = used_q - CW'(1);
  assign sh_m1   = sh_q - CW'(1);
  assign sh_m2   = sh_q - CW'(2);

  // Lower-bound search state and the entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.wr_new) begin
      used_q <= used_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      key_q      <= key_ext[KEY_WIDTH-1:0];
      val_in_q   <= val_ext[VALUE_WIDTH-1:0];
      lo_q       <= '0;
      hi_q       <= used_q;
      eq_q       <= 1'b0;
    end else if (cmd_i.search_upd) begin
      if (rd_key < key_q) begin
        lo_q <= mid + CW'(1);
      end else begin
        // The last mid that lowers hi is the lower bound itself.
        hi_q     <= mid;
        eq_q     <= (rd_key == key_q);
        hitval_q <= rd_val;
      end
    end
    if (cmd_i.shift_prime) begin
      sh_q <= used_q;
    end else if (cmd_i.shift_step) begin
      sh_q <= sh_m1;
    end
  end

  // During a shift the read runs one entry ahead of the write.
  always_comb begin
    raddr = mid[AW-1:0];
    if (cmd_i.shift_prime) begin
      raddr = used_m1[AW-1:0];
    end else if (cmd_i.shift_step) begin
      raddr = sh_m2[AW-1:0];
    end
  end

  assign we    = cmd_i.wr_replace | cmd_i.shift_step | cmd_i.wr_new;
  assign waddr = cmd_i.shift_step ? sh_q[AW-1:0] : lo_q[AW-1:0];
  assign wdata = cmd_i.shift_step ? rdata : {key_q, val_in_q};

  stf_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.search_busy = lo_q < hi_q;
  assign stat_o.is_find     = (req_type_q == REQ_FIND);
  assign stat_o.need_shift  = lo_q < used_q;
  assign stat_o.hit         = eq_q && (lo_q < used_q);
  assign stat_o.full        = (used_q == CW'(DEPTH));
  assign stat_o.shift_last  = (sh_m1 == lo_q);
  assign stat_o.out_free    = !out_valid_o || out_ready_i;

  // Result register.
  assign hitval_ext = {{(64 - VALUE_WIDTH){1'b0}}, hitval_q};
  assign lo_ext     = 32'(lo_q);
  assign used_ext   = 32'(used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      status_o       <= cmd_i.rsp_status;
      position_o     <= lo_ext[POS_W-1:0];
      stored_value_o <= (cmd_i.rsp_status == ST_FOUND) ? hitval_ext[VAL_IN_W-1:0] : '0;
      entry_count_o  <= used_ext[POS_W-1:0];
    end
  end
endmodule

FILE: rtl/sorted_table_insert_find.sv
// Sorted key/value table with lower-bound search, replace and shifting insert.
// One item is worked at a time. A find does one memory read and one compare per
// search step over the n entries in use; an insert that shifts entries up moves
// each of them one place before the new entry is written. A result that is not
// taken holds off the next item. Reset clears the count and control state only.
module sorted_table_insert_find
  import stf_pkg::*;
#(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stf_req_if.sink          req_i,
  stf_rsp_if.source        rsp_o
);
  stf_cmd_t  cmd;
  stf_stat_t stat;

  stf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stf_dp #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_i.req_type),
    .key_i          (req_i.key),
    .value_i        (req_i.value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .position_o     (rsp_o.position),
    .stored_value_o (rsp_o.stored_value),
    .entry_count_o  (rsp_o.entry_count)
  );

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while an item is still in work");

  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |-> !stat.full)
    else $error("new entry written into a full table");

  a_rsp_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_rsp |-> stat.out_free)
    else $error("result overwritten before it was taken");

  a_search_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.search_rd |=> cmd.search_upd)
    else $error("search read not followed by its compare");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.load_rsp))
    else $error("result shown without a load");
endmodule

FILE: tb/sv/sorted_table_insert_find_test.sv
// Self-checking testbench for sorted_table_insert_find: a directed walk over
// edge keys, then random insert/find traffic that fills the table to capacity.
// Depends on stf_pkg, stf_req_if, stf_rsp_if and the block itself.
module sorted_table_insert_find_test;
  import stf_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned PAUSE_EVERY  = 500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct {
    req_e                op;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_IN_W-1:0] value;
  } table_req_t;

  typedef struct {
    status_e             status;
    logic [POS_W-1:0]    position;
    logic [VAL_IN_W-1:0] stored_value;
    logic [POS_W-1:0]    entry_count;
  } table_rsp_t;

  typedef struct {
    table_req_t req;
    bit         typed;
    table_rsp_t rsp;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stf_req_if req_if ();
  stf_rsp_if rsp_if ();

  sorted_table_insert_find #(
    .DEPTH      (TABLE_DEPTH),
    .KEY_WIDTH  (KEY_IN_W),
    .VALUE_WIDTH(VAL_IN_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the table contents, kept in step with accepted requests.
  logic [KEY_IN_W-1:0] table_keys [TABLE_DEPTH];
  logic [VAL_IN_W-1:0] table_vals [TABLE_DEPTH];
  int unsigned         table_used = 0;

  table_rsp_t    pending_rsps [$];
  directed_row_t directed_rows [$];
  int unsigned   fail_count = 0;
  bit            stim_done = 1'b0;

  function automatic table_rsp_t apply_table_request(input table_req_t r);
    table_rsp_t  rsp;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          hit;
    lo = 0;
    hi = table_used;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (table_keys[mid] < r.key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < table_used) && (table_keys[lo] == r.key);
    rsp.position = POS_W'(lo);
    rsp.stored_value = '0;
    if (r.op == REQ_FIND) begin
      rsp.status = hit ? ST_FOUND : ST_MISSING;
      if (hit) rsp.stored_value = table_vals[lo];
    end else if (hit) begin
      table_vals[lo] = r.value;
      rsp.status = ST_REPLACED;
    end else if (table_used >= TABLE_DEPTH) begin
      rsp.status = ST_FULL;
    end else begin
      for (int unsigned i = table_used; i > lo; i--) begin
        table_keys[i] = table_keys[i-1];
        table_vals[i] = table_vals[i-1];
      end
      table_keys[lo] = r.key;
      table_vals[lo] = r.value;
      table_used++;
      rsp.status = ST_INSERTED;
    end
    rsp.entry_count = POS_W'(table_used);
    return rsp;
  endfunction

  task automatic add_row(input req_e op, input logic [KEY_IN_W-1:0] key,
                         input logic [VAL_IN_W-1:0] value, input bit typed,
                         input status_e st, input int unsigned pos,
                         input logic [VAL_IN_W-1:0] sval, input int unsigned cnt);
    directed_row_t row;
    row.req = '{op, key, value};
    row.typed = typed;
    row.rsp = '{st, POS_W'(pos), sval, POS_W'(cnt)};
    directed_rows.push_back(row);
  endtask

  // Random request: mostly keys already in the table or right next to them,
  // so that replaces, hits and inserts between neighbors are common.
  function automatic table_req_t draw_request();
    table_req_t  r;
    int unsigned pick;
    int unsigned slot;
    logic [KEY_IN_W-1:0] k;
    pick = $urandom_range(99, 0);
    slot = (table_used > 0) ? $urandom_range(table_used - 1, 0) : 0;
    if (pick < 40 && table_used > 0) begin
      k = table_keys[slot];
    end else if (pick < 55 && table_used > 0) begin
      k = $urandom_range(1, 0) ? table_keys[slot] + 1'b1 : table_keys[slot] - 1'b1;
    end else if (pick < 62) begin
      case ($urandom_range(3, 0))
        0: k = '0;
        1: k = '1;
        2: k = {1'b1, {(KEY_IN_W-1){1'b0}}};
        default: k = {1'b0, {(KEY_IN_W-1){1'b1}}};
      endcase
    end else begin
      k = $urandom;
    end
    r.key = k;
    // Lean toward inserts while the table fills, then balance once it is full.
    if (table_used < TABLE_DEPTH) r.op = ($urandom_range(99, 0) < 70) ? REQ_INSERT : REQ_FIND;
    else r.op = $urandom_range(1, 0) ? REQ_INSERT : REQ_FIND;
    case ($urandom_range(9, 0))
      0: r.value = '0;
      1: r.value = '1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  // Every third stretch of 128 items draws no idle wait, save where the driver forces a drain pause.
  function automatic int unsigned draw_wait(input int unsigned idx);
    if ((idx / 128) % 3 == 1) return 0;
    return $urandom_range(16, 0);
  endfunction

  initial begin : drive_requests
    table_req_t  item;
    table_rsp_t  predicted;
    int unsigned n_dir;
    int unsigned gap;
    bit          drain_first;
    bit          typed;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.key      <= '0;
    req_if.value    <= '0;

    add_row(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 1, ST_MISSING,  0, 32'h0, 0);
    add_row(REQ_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_MISSING,  0, 32'h0, 0);
    add_row(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_INSERTED, 0, 32'h0, 1);
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_INSERTED, 1, 32'h0, 2);
    add_row(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 1, ST_FOUND,    0, 32'hFFFF_FFFF, 2);
    add_row(REQ_FIND,   32'hFFFF_FFFF, 32'h1234_5678, 1, ST_FOUND,    1, 32'h0, 2);
    add_row(REQ_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1, ST_REPLACED, 0, 32'h0, 2);
    add_row(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 1, ST_FOUND,    0, 32'h5A5A_5A5A, 2);
    add_row(REQ_FIND,   32'h0000_0001, 32'h0000_0000, 1, ST_MISSING,  1, 32'h0, 2);
    add_row(REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1, ST_INSERTED, 1, 32'h0, 3);
    add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 1, ST_INSERTED, 1, 32'h0, 4);
    add_row(REQ_INSERT, 32'h0000_0001, 32'h8000_0000, 1, ST_INSERTED, 1, 32'h0, 5);
    add_row(REQ_INSERT, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 1, ST_INSERTED, 4, 32'h0, 6);
    add_row(REQ_FIND,   32'h8000_0000, 32'h0000_0000, 1, ST_FOUND,    3, 32'hA5A5_A5A5, 6);
    add_row(REQ_FIND,   32'h7FFF_FFFF, 32'h0000_0000, 1, ST_FOUND,    2, 32'h0000_0001, 6);
    add_row(REQ_FIND,   32'h0000_0002, 32'h0000_0000, 1, ST_MISSING,  2, 32'h0, 6);
    add_row(REQ_FIND,   32'hFFFF_FFFD, 32'h0000_0000, 1, ST_MISSING,  4, 32'h0, 6);
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 1, ST_REPLACED, 5, 32'h0, 6);
    add_row(REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1, ST_FOUND,    5, 32'h1234_5678, 6);
    add_row(REQ_INSERT, 32'h0000_FFFF, 32'hDEAD_BEEF, 0, ST_INSERTED, 0, 32'h0, 0);
    add_row(REQ_FIND,   32'h0000_FFFF, 32'h0000_0000, 0, ST_INSERTED, 0, 32'h0, 0);
    add_row(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 0, ST_INSERTED, 0, 32'h0, 0);
    add_row(REQ_FIND,   32'hAAAA_AAAA, 32'h0000_0000, 0, ST_INSERTED, 0, 32'h0, 0);
    n_dir = directed_rows.size();

    wait (rst_ni);
    @(posedge clk_i);
    for (int unsigned i = 0; i < n_dir + RANDOM_ITEMS; i++) begin
      if (i < n_dir) begin
        item  = directed_rows[i].req;
        typed = directed_rows[i].typed;
      end else begin
        item  = draw_request();
        typed = 1'b0;
      end
      drain_first = (i >= n_dir) && ((i - n_dir) % PAUSE_EVERY == 0);
      gap = draw_wait(i);
      if (drain_first && gap == 0) gap = 1;
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        while (drain_first && pending_rsps.size() != 0) @(posedge clk_i);
        repeat (gap) @(posedge clk_i);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= item.op;
      req_if.key      <= item.key;
      req_if.value    <= item.value;
      do @(posedge clk_i); while (!req_if.ready);
      predicted = apply_table_request(item);
      pending_rsps.push_back(typed ? directed_rows[i].rsp : predicted);
    end
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : accept_results
    table_rsp_t  want;
    int unsigned n_rsp;
    int unsigned stall;
    n_rsp = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = draw_wait(n_rsp + 64);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      if (pending_rsps.size() == 0) begin
        $error("result item with no request outstanding: status %0d position %0d",
               rsp_if.status, rsp_if.position);
        fail_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp_if.position);
          fail_count++;
        end
        if (rsp_if.stored_value !== want.stored_value) begin
          $error("stored_value: expected %h, got %h", want.stored_value, rsp_if.stored_value);
          fail_count++;
        end
        if (rsp_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_if.entry_count);
          fail_count++;
        end
      end
      n_rsp++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_table_insert_find regression: fail");
    $finish;
  end

  initial begin : run_control
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_table_insert_find regression: pass");
    end else begin
      $display("sorted_table_insert_find regression: fail");
    end
    $finish;
  end

endmodule
